// ===== rtl/bup_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BGP UPDATE parser package
// Shared types, record codes, attribute codes and small decode functions.
// ----------------------------------------------------------------------------
package bup_pkg;

  localparam int unsigned MAX_PREFIX_BITS = 32;

  // Parser phases.
  typedef enum logic [3:0] {
    P_IDLE, P_WLEN, P_WPLEN, P_WPFX, P_ALEN, P_AFLAGS, P_ATYPE, P_ALENB,
    P_AVAL, P_ASKIP, P_ASEGT, P_ASEGN, P_ASN, P_NPLEN, P_NPFX
  } phase_t;

  // Record kinds.
  localparam logic [3:0] K_WITHDRAWN  = 4'd0;
  localparam logic [3:0] K_ANNOUNCED  = 4'd1;
  localparam logic [3:0] K_ORIGIN     = 4'd2;
  localparam logic [3:0] K_NEXT_HOP   = 4'd3;
  localparam logic [3:0] K_MED        = 4'd4;
  localparam logic [3:0] K_LOCAL_PREF = 4'd5;
  localparam logic [3:0] K_ATOMIC     = 4'd6;
  localparam logic [3:0] K_AGGREGATOR = 4'd7;
  localparam logic [3:0] K_COMMUNITY  = 4'd8;
  localparam logic [3:0] K_ORIGINATOR = 4'd9;
  localparam logic [3:0] K_CLUSTER    = 4'd10;
  localparam logic [3:0] K_ASN        = 4'd11;
  localparam logic [3:0] K_LARGE_COMM = 4'd12;
  localparam logic [3:0] K_PATH_LIMIT = 4'd13;
  localparam logic [3:0] K_SKIPPED    = 4'd14;
  localparam logic [3:0] K_END        = 4'd15;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_LENGTH    = 2'd1;
  localparam logic [1:0] ST_PREFIX    = 2'd2;
  localparam logic [1:0] ST_DUPLICATE = 2'd3;

  // Path attribute type codes.
  localparam logic [7:0] AT_ORIGIN      = 8'd1;
  localparam logic [7:0] AT_AS_PATH     = 8'd2;
  localparam logic [7:0] AT_NEXT_HOP    = 8'd3;
  localparam logic [7:0] AT_MED         = 8'd4;
  localparam logic [7:0] AT_LOCAL_PREF  = 8'd5;
  localparam logic [7:0] AT_ATOMIC      = 8'd6;
  localparam logic [7:0] AT_AGGREGATOR  = 8'd7;
  localparam logic [7:0] AT_COMMUNITY   = 8'd8;
  localparam logic [7:0] AT_ORIGINATOR  = 8'd9;
  localparam logic [7:0] AT_CLUSTER     = 8'd10;
  localparam logic [7:0] AT_AS4_PATH    = 8'd17;
  localparam logic [7:0] AT_AS4_AGGR    = 8'd18;
  localparam logic [7:0] AT_PATH_LIMIT  = 8'd21;
  localparam logic [7:0] AT_LARGE_COMM  = 8'd32;

  localparam logic [7:0] FLAG_EXT_LEN = 8'h10;

  // One result record.
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  atype;
    logic [7:0]  aflags;
    logic [31:0] va;
    logic [31:0] vb;
    logic [31:0] vc;
    logic [5:0]  plen;
    logic [7:0]  seg;
    logic [1:0]  status;
    logic        last;
  } rec_t;

  // Seen-map access from the parser.
  typedef struct packed {
    logic       rd_en;
    logic [7:0] rd_addr;
    logic       wr_en;
    logic [7:0] wr_addr;
    logic       clear;
  } seen_req_t;

  // Width of an AS number in bytes for the given attribute type.
  function automatic logic [3:0] asn_size(input logic [7:0] t, input logic asn4);
    if (t == AT_AS4_PATH || t == AT_AS4_AGGR || asn4) begin
      return 4'd4;
    end
    return 4'd2;
  endfunction

  // Size of one value group of a decoded attribute; zero when not decoded.
  function automatic logic [3:0] group_of(input logic [7:0] t, input logic asn4);
    logic [3:0] g;
    case (t)
      AT_ORIGIN:     g = 4'd1;
      AT_NEXT_HOP,
      AT_MED,
      AT_LOCAL_PREF,
      AT_COMMUNITY,
      AT_ORIGINATOR,
      AT_CLUSTER:    g = 4'd4;
      AT_AGGREGATOR: g = 4'(asn_size(t, asn4) + 4'd4);
      AT_AS4_AGGR:   g = 4'd8;
      AT_PATH_LIMIT: g = 4'd3;
      AT_LARGE_COMM: g = 4'd12;
      default:       g = 4'd0;
    endcase
    return g;
  endfunction

  function automatic logic [3:0] kind_of(input logic [7:0] t);
    logic [3:0] k;
    case (t)
      AT_ORIGIN:     k = K_ORIGIN;
      AT_NEXT_HOP:   k = K_NEXT_HOP;
      AT_MED:        k = K_MED;
      AT_LOCAL_PREF: k = K_LOCAL_PREF;
      AT_AGGREGATOR,
      AT_AS4_AGGR:   k = K_AGGREGATOR;
      AT_COMMUNITY:  k = K_COMMUNITY;
      AT_ORIGINATOR: k = K_ORIGINATOR;
      AT_CLUSTER:    k = K_CLUSTER;
      AT_PATH_LIMIT: k = K_PATH_LIMIT;
      default:       k = K_LARGE_COMM;
    endcase
    return k;
  endfunction

  function automatic logic repeating(input logic [7:0] t);
    return (t == AT_COMMUNITY) || (t == AT_CLUSTER) || (t == AT_LARGE_COMM);
  endfunction

  // Divisibility by twelve: low two bits clear and the rest a multiple of three,
  // found by folding base-four digits (four is one modulo three).
  function automatic logic div_by_12(input logic [15:0] v);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    s1 = 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8]) +
         5'(v[11:10]) + 5'(v[13:12]) + 5'(v[15:14]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    return (v[1:0] == 2'b00) && (s3 == 3'd0 || s3 == 3'd3);
  endfunction

  function automatic rec_t make_rec(input logic [3:0] kind, input logic [15:0] tf,
                                    input logic [31:0] a, input logic [31:0] b,
                                    input logic [31:0] c, input logic [5:0] plen,
                                    input logic [7:0] seg, input logic [1:0] st);
    rec_t r;
    r.kind   = kind;
    r.atype  = tf[15:8];
    r.aflags = tf[7:0];
    r.va     = a;
    r.vb     = b;
    r.vc     = c;
    r.plen   = plen;
    r.seg    = seg;
    r.status = st;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/bup_seen_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seen-attribute map
// 256 x 1 synchronous memory of attribute types already met in this message,
// qualified by per-entry valid bits that a message start clears at once.
// ----------------------------------------------------------------------------
module bup_seen_map (
  input  logic                 clk,
  input  logic                 rst,
  input  bup_pkg::seen_req_t   req,
  output logic                 seen
);
  import bup_pkg::*;

  logic         mem [256];
  logic         mem_q;
  logic [255:0] valid;
  logic         valid_q;

  // Memory port: registered read, single write.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      mem_q <= mem[req.rd_addr];
    end
    if (req.wr_en) begin
      mem[req.wr_addr] <= 1'b1;
    end
  end

  // Valid bits, cleared at reset and at every message start.
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        valid_q <= valid[req.rd_addr];
      end
    end
  end

  assign seen = valid_q & mem_q;

  // A write never lands on a cleared map in the same cycle.
  a_no_clear_write: assert property (@(posedge clk) disable iff (rst)
    !(req.clear && req.wr_en)) else $error("seen map written during clear");

  // Read and write of the map never coincide.
  a_no_rd_wr: assert property (@(posedge clk) disable iff (rst)
    !(req.rd_en && req.wr_en)) else $error("seen map read and write together");

  // A marked entry reads back as seen.
  a_mark_seen: assert property (@(posedge clk) disable iff (rst)
    (req.wr_en && !req.clear) |=> valid[$past(req.wr_addr)])
    else $error("seen map mark lost");

endmodule

// ===== rtl/bup_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UPDATE body parser
// Byte-wise phase machine over the message: counters, field shifter and the
// record builder. Each accepted byte yields up to a record and an end record.
// ----------------------------------------------------------------------------
module bup_parser #(
  parameter int unsigned MAX_BODY_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          data_byte,
  input  logic                start_of_message,
  input  logic [11:0]         body_length,
  input  logic                asn4,
  input  logic                seen,
  output bup_pkg::seen_req_t  seen_req,
  output logic                main_v,
  output bup_pkg::rec_t       main_rec,
  output logic                end_v,
  output bup_pkg::rec_t       end_rec
);
  import bup_pkg::*;

  localparam int unsigned MW = $clog2(MAX_BODY_BYTES + 1);

  phase_t          phase, phase_next;
  logic [MW-1:0]   msg_left, msg_left_next;
  logic [MW-1:0]   sec_left, sec_left_next;
  logic [MW-1:0]   attr_left, attr_left_next;
  logic [31:0]     fshift, fshift_next;
  logic [3:0]      ftaken, ftaken_next;
  logic [15:0]     tflags, tflags_next;
  logic [7:0]      seg_kind, seg_kind_next;
  logic [7:0]      asn_left, asn_left_next;
  logic [31:0]     held0, held0_next;
  logic [31:0]     held1, held1_next;
  logic [5:0]      plen, plen_next;
  logic [1:0]      end_st;
  logic            mark;

  // Next-state and record logic for one accepted byte.
  always_comb begin
    logic [7:0]      t;
    logic [3:0]      asz;
    logic [3:0]      g;
    logic [3:0]      nb;
    logic [15:0]     len;
    logic [MW-1:0]   avail;
    logic [9:0]      prod;
    logic [31:0]     sh;
    logic [3:0]      pkind;
    phase_next     = phase;
    msg_left_next  = msg_left;
    sec_left_next  = sec_left;
    attr_left_next = attr_left;
    fshift_next    = fshift;
    ftaken_next    = ftaken;
    tflags_next    = tflags;
    seg_kind_next  = seg_kind;
    asn_left_next  = asn_left;
    held0_next     = held0;
    held1_next     = held1;
    plen_next      = plen;
    main_v         = 1'b0;
    main_rec       = '0;
    end_v          = 1'b0;
    end_st         = ST_OK;
    mark           = 1'b0;
    len            = '0;
    avail          = '0;
    prod           = '0;
    sh             = '0;
    nb             = '0;

    // A start abandons any message in progress.
    if (start_of_message) begin
      phase_next     = P_WLEN;
      msg_left_next  = (32'(body_length) > 32'(MAX_BODY_BYTES)) ?
                       MW'(MAX_BODY_BYTES) : MW'(body_length);
      sec_left_next  = '0;
      attr_left_next = '0;
      fshift_next    = '0;
      ftaken_next    = '0;
      tflags_next    = '0;
      seg_kind_next  = '0;
      asn_left_next  = '0;
      held0_next     = '0;
      held1_next     = '0;
      plen_next      = '0;
    end

    t     = tflags_next[15:8];
    asz   = asn_size(t, asn4);
    g     = group_of(t, asn4);
    pkind = (phase_next == P_WPLEN || phase_next == P_WPFX) ? K_WITHDRAWN : K_ANNOUNCED;

    if (phase_next != P_IDLE) begin
      if (msg_left_next == '0) begin
        end_v      = 1'b1;
        end_st     = ST_LENGTH;
        phase_next = P_IDLE;
      end else begin
        msg_left_next = msg_left_next - 1'b1;
        case (phase_next)
          // Two-byte section lengths.
          P_WLEN, P_ALEN: begin
            fshift_next = {fshift_next[23:0], data_byte};
            ftaken_next = ftaken_next + 4'd1;
            if (ftaken_next >= 4'd2) begin
              len = fshift_next[15:0];
              if (32'(len) > 32'(msg_left_next)) begin
                end_v      = 1'b1;
                end_st     = ST_LENGTH;
                phase_next = P_IDLE;
              end else begin
                sec_left_next = MW'(len);
                fshift_next   = '0;
                ftaken_next   = '0;
                if (phase_next == P_WLEN) begin
                  phase_next = (len != '0) ? P_WPLEN : P_ALEN;
                end else begin
                  phase_next = (len != '0) ? P_AFLAGS : P_NPLEN;
                end
              end
            end
          end
          // Prefix length byte.
          P_WPLEN, P_NPLEN: begin
            if (phase_next == P_WPLEN) begin
              sec_left_next = sec_left_next - 1'b1;
              avail = sec_left_next;
            end else begin
              avail = msg_left_next;
            end
            if (32'(data_byte) > MAX_PREFIX_BITS) begin
              end_v      = 1'b1;
              end_st     = ST_PREFIX;
              phase_next = P_IDLE;
            end else begin
              nb = 4'((data_byte + 8'd7) >> 3);
              if (32'(nb) > 32'(avail)) begin
                end_v      = 1'b1;
                end_st     = ST_LENGTH;
                phase_next = P_IDLE;
              end else begin
                plen_next   = data_byte[5:0];
                fshift_next = '0;
                ftaken_next = '0;
                if (nb == 4'd0) begin
                  main_v   = 1'b1;
                  main_rec = make_rec(pkind, 16'd0, 32'd0, 32'd0, 32'd0,
                                      data_byte[5:0], 8'd0, ST_OK);
                end else begin
                  phase_next = (phase_next == P_WPLEN) ? P_WPFX : P_NPFX;
                end
              end
            end
            if (phase_next == P_WPLEN && sec_left_next == '0) begin
              fshift_next = '0;
              ftaken_next = '0;
              phase_next  = P_ALEN;
            end
          end
          // Prefix address bytes, filled from the top.
          P_WPFX, P_NPFX: begin
            if (phase_next == P_WPFX) begin
              sec_left_next = sec_left_next - 1'b1;
            end
            nb = 4'((7'(plen_next) + 7'd7) >> 3);
            case (ftaken_next[1:0])
              2'd0:    sh = {data_byte, 24'd0};
              2'd1:    sh = {8'd0, data_byte, 16'd0};
              2'd2:    sh = {16'd0, data_byte, 8'd0};
              default: sh = {24'd0, data_byte};
            endcase
            fshift_next = fshift_next | sh;
            ftaken_next = ftaken_next + 4'd1;
            if (ftaken_next >= nb) begin
              main_v     = 1'b1;
              main_rec   = make_rec(pkind, 16'd0, fshift_next, 32'd0, 32'd0,
                                    plen_next, 8'd0, ST_OK);
              phase_next = (phase_next == P_WPFX) ? P_WPLEN : P_NPLEN;
            end
            if (phase_next == P_WPLEN && sec_left_next == '0) begin
              fshift_next = '0;
              ftaken_next = '0;
              phase_next  = P_ALEN;
            end
          end
          P_AFLAGS: begin
            sec_left_next = sec_left_next - 1'b1;
            tflags_next   = {8'd0, data_byte};
            if (sec_left_next == '0) begin
              end_v      = 1'b1;
              end_st     = ST_LENGTH;
              phase_next = P_IDLE;
            end else begin
              phase_next = P_ATYPE;
            end
          end
          P_ATYPE: begin
            sec_left_next = sec_left_next - 1'b1;
            tflags_next   = {data_byte, tflags_next[7:0]};
            if (sec_left_next == '0) begin
              end_v      = 1'b1;
              end_st     = ST_LENGTH;
              phase_next = P_IDLE;
            end else begin
              fshift_next = '0;
              ftaken_next = '0;
              phase_next  = P_ALENB;
            end
          end
          // Attribute length, then header decisions.
          P_ALENB: begin
            sec_left_next = sec_left_next - 1'b1;
            fshift_next   = {fshift_next[23:0], data_byte};
            ftaken_next   = ftaken_next + 4'd1;
            if (ftaken_next < (((tflags_next[7:0] & FLAG_EXT_LEN) != 8'd0) ? 4'd2 : 4'd1))
            begin
              if (sec_left_next == '0) begin
                end_v      = 1'b1;
                end_st     = ST_LENGTH;
                phase_next = P_IDLE;
              end
            end else begin
              len = fshift_next[15:0];
              if (32'(len) > 32'(sec_left_next)) begin
                end_v      = 1'b1;
                end_st     = ST_LENGTH;
                phase_next = P_IDLE;
              end else begin
                attr_left_next = MW'(len);
                fshift_next    = '0;
                ftaken_next    = '0;
                phase_next     = P_ASKIP;
                if (seen) begin
                  main_v   = 1'b1;
                  main_rec = make_rec(K_SKIPPED, tflags_next, 32'd0, 32'd0, 32'd0,
                                      6'd0, 8'd0, ST_DUPLICATE);
                end else begin
                  mark = 1'b1;
                  if (t == AT_AS_PATH || t == AT_AS4_PATH) begin
                    phase_next = (len == '0) ? P_AFLAGS : P_ASEGT;
                  end else if (t == AT_ATOMIC) begin
                    main_v   = 1'b1;
                    main_rec = make_rec(K_ATOMIC, tflags_next, 32'd0, 32'd0, 32'd0,
                                        6'd0, 8'd0, ST_OK);
                  end else if (g == 4'd0) begin
                    main_v   = 1'b1;
                    main_rec = make_rec(K_SKIPPED, tflags_next, 32'd0, 32'd0, 32'd0,
                                        6'd0, 8'd0, ST_OK);
                  end else if (t == AT_LARGE_COMM && !div_by_12(len)) begin
                    end_v      = 1'b1;
                    end_st     = ST_LENGTH;
                    phase_next = P_IDLE;
                  end else if (len < 16'(g)) begin
                    if (!repeating(t)) begin
                      main_v   = 1'b1;
                      main_rec = make_rec(K_SKIPPED, tflags_next, 32'd0, 32'd0,
                                          32'd0, 6'd0, 8'd0, ST_OK);
                    end
                  end else begin
                    phase_next = P_AVAL;
                  end
                end
                // Skip or finish the attribute where no value is decoded.
                if (phase_next == P_ASKIP && attr_left_next == '0) begin
                  phase_next = P_AFLAGS;
                end
                if (phase_next == P_AFLAGS) begin
                  phase_next = (sec_left_next != '0) ? P_AFLAGS : P_NPLEN;
                end
              end
            end
          end
          // Decoded attribute value bytes.
          P_AVAL: begin
            sec_left_next  = sec_left_next - 1'b1;
            attr_left_next = attr_left_next - 1'b1;
            fshift_next    = {fshift_next[23:0], data_byte};
            ftaken_next    = ftaken_next + 4'd1;
            if (((t == AT_AGGREGATOR || t == AT_AS4_AGGR) && ftaken_next == asz) ||
                (t == AT_PATH_LIMIT && ftaken_next == 4'd1) ||
                (t == AT_LARGE_COMM && ftaken_next == 4'd4)) begin
              held0_next  = fshift_next;
              fshift_next = '0;
            end else if (t == AT_LARGE_COMM && ftaken_next == 4'd8) begin
              held1_next  = fshift_next;
              fshift_next = '0;
            end
            if (ftaken_next >= g) begin
              main_v = 1'b1;
              if (t == AT_AGGREGATOR || t == AT_AS4_AGGR || t == AT_PATH_LIMIT) begin
                main_rec = make_rec(kind_of(t), tflags_next, held0_next, fshift_next,
                                    32'd0, 6'd0, 8'd0, ST_OK);
              end else if (t == AT_LARGE_COMM) begin
                main_rec = make_rec(K_LARGE_COMM, tflags_next, held0_next, held1_next,
                                    fshift_next, 6'd0, 8'd0, ST_OK);
              end else begin
                main_rec = make_rec(kind_of(t), tflags_next, fshift_next, 32'd0,
                                    32'd0, 6'd0, 8'd0, ST_OK);
              end
              fshift_next = '0;
              ftaken_next = '0;
              if (!(repeating(t) && 32'(attr_left_next) >= 32'(g))) begin
                if (attr_left_next != '0) begin
                  phase_next = P_ASKIP;
                end else begin
                  phase_next = (sec_left_next != '0) ? P_AFLAGS : P_NPLEN;
                end
              end
            end
          end
          P_ASKIP: begin
            sec_left_next  = sec_left_next - 1'b1;
            attr_left_next = attr_left_next - 1'b1;
            if (attr_left_next == '0) begin
              fshift_next = '0;
              ftaken_next = '0;
              phase_next  = (sec_left_next != '0) ? P_AFLAGS : P_NPLEN;
            end
          end
          P_ASEGT: begin
            sec_left_next  = sec_left_next - 1'b1;
            attr_left_next = attr_left_next - 1'b1;
            seg_kind_next  = data_byte;
            if (attr_left_next == '0) begin
              end_v      = 1'b1;
              end_st     = ST_LENGTH;
              phase_next = P_IDLE;
            end else begin
              phase_next = P_ASEGN;
            end
          end
          P_ASEGN: begin
            sec_left_next  = sec_left_next - 1'b1;
            attr_left_next = attr_left_next - 1'b1;
            prod = (asz == 4'd4) ? {data_byte, 2'b00} : {1'b0, data_byte, 1'b0};
            if (32'(prod) > 32'(attr_left_next)) begin
              end_v      = 1'b1;
              end_st     = ST_LENGTH;
              phase_next = P_IDLE;
            end else begin
              asn_left_next = data_byte;
              if (data_byte == 8'd0) begin
                if (attr_left_next == '0) begin
                  fshift_next = '0;
                  ftaken_next = '0;
                  phase_next  = (sec_left_next != '0) ? P_AFLAGS : P_NPLEN;
                end else begin
                  phase_next = P_ASEGT;
                end
              end else begin
                fshift_next = '0;
                ftaken_next = '0;
                phase_next  = P_ASN;
              end
            end
          end
          P_ASN: begin
            sec_left_next  = sec_left_next - 1'b1;
            attr_left_next = attr_left_next - 1'b1;
            fshift_next    = {fshift_next[23:0], data_byte};
            ftaken_next    = ftaken_next + 4'd1;
            if (ftaken_next >= asz) begin
              main_v      = 1'b1;
              main_rec    = make_rec(K_ASN, tflags_next, fshift_next, 32'd0, 32'd0,
                                     6'd0, seg_kind_next, ST_OK);
              fshift_next = '0;
              ftaken_next = '0;
              if (asn_left_next != 8'd0) begin
                asn_left_next = asn_left_next - 8'd1;
              end
              if (!(asn_left_next != 8'd0 && attr_left_next != '0)) begin
                if (attr_left_next == '0) begin
                  phase_next = (sec_left_next != '0) ? P_AFLAGS : P_NPLEN;
                end else begin
                  phase_next = P_ASEGT;
                end
              end
            end
          end
          default: begin
            phase_next = P_IDLE;
          end
        endcase

        // Body exhausted: clean end only between announced prefixes.
        if (phase_next != P_IDLE && msg_left_next == '0) begin
          end_v      = 1'b1;
          end_st     = (phase_next == P_NPLEN) ? ST_OK : ST_LENGTH;
          phase_next = P_IDLE;
        end
      end
    end
  end

  // End record.
  always_comb begin
    end_rec        = '0;
    end_rec.kind   = K_END;
    end_rec.status = end_st;
    end_rec.last   = 1'b1;
  end

  // Seen-map requests: look the type up as it arrives, mark at the header.
  always_comb begin
    seen_req.clear   = fire && start_of_message;
    seen_req.rd_en   = fire && !start_of_message && (phase == P_ATYPE);
    seen_req.rd_addr = data_byte;
    seen_req.wr_en   = fire && mark;
    seen_req.wr_addr = tflags[15:8];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= P_IDLE;
      msg_left  <= '0;
      sec_left  <= '0;
      attr_left <= '0;
      ftaken    <= '0;
      asn_left  <= '0;
    end else if (fire) begin
      phase     <= phase_next;
      msg_left  <= msg_left_next;
      sec_left  <= sec_left_next;
      attr_left <= attr_left_next;
      ftaken    <= ftaken_next;
      asn_left  <= asn_left_next;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    if (rst) begin
      fshift   <= '0;
      tflags   <= '0;
      seg_kind <= '0;
      held0    <= '0;
      held1    <= '0;
      plen     <= '0;
    end else if (fire) begin
      fshift   <= fshift_next;
      tflags   <= tflags_next;
      seg_kind <= seg_kind_next;
      held0    <= held0_next;
      held1    <= held1_next;
      plen     <= plen_next;
    end
  end

  // After an end record the parser waits for the next start.
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && end_v) |=> (phase == P_IDLE)) else $error("parser busy after end");

  // The message count only falls within a message.
  a_msg_falls: assert property (@(posedge clk) disable iff (rst)
    (fire && !start_of_message) |=> (msg_left <= $past(msg_left)))
    else $error("message count rose without a start");

  // An attribute never outlasts its section.
  a_attr_in_sec: assert property (@(posedge clk) disable iff (rst)
    (phase == P_AVAL || phase == P_ASKIP || phase == P_ASN) |-> (attr_left <= sec_left))
    else $error("attribute longer than its section");

endmodule

// ===== rtl/bup_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Four-entry queue taking up to two records a cycle and giving one.
// ----------------------------------------------------------------------------
module bup_out_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push0,
  input  bup_pkg::rec_t  data0,
  input  logic           push1,
  input  bup_pkg::rec_t  data1,
  output logic           room,
  output logic           out_valid,
  output bup_pkg::rec_t  out_rec,
  input  logic           out_ready
);
  import bup_pkg::*;

  rec_t       q [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;
  logic [2:0] count_next;
  logic       pop;

  assign pop        = out_valid && out_ready;
  assign room       = (count <= 3'd2);
  assign out_valid  = (count != 3'd0);
  assign out_rec    = q[rptr];
  assign count_next = count + 3'(push0) + 3'(push1) - 3'(pop);

  // Storage.
  always_ff @(posedge clk) begin
    if (push0) begin
      q[wptr] <= data0;
    end
    if (push1) begin
      q[2'(wptr + 2'd1)] <= data1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + 2'(push0) + 2'(push1);
      rptr  <= rptr + 2'(pop);
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count <= 3'd4)) else $error("result queue overflow");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push1 |-> push0) else $error("second record without first");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push0 |-> (count - 3'(pop) <= 3'd2)) else $error("push without room");

endmodule

// ===== rtl/bgp_update_byte_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BGP UPDATE byte parser
// Takes an UPDATE body a byte at a time and gives prefix and attribute records.
// ----------------------------------------------------------------------------
// Input stream s_*: one body byte per transaction; s_tuser marks the first
// byte of a body, which also carries the body length in s_tdata.
// Output stream m_*: one record per transaction, record kind in m_tuser,
// m_tlast on the end record that closes every message.
// Configuration cfg_*: asn_four_byte, always ready; write it between messages.
// A byte is taken every cycle while the four-entry result queue has room for
// two records, so the sustained rate is one byte per cycle; a record is
// registered in the queue with the byte that completes it. A byte can give two
// records (a record and the end), drained one per cycle by the queue while m_tready is high.
// The seen-attribute map is a 256 x 1 memory read when the type byte arrives
// and marked when the length is complete; its valid bits clear at each start.
// Reset empties the queue and leaves the parser idle, dropping bytes until a
// start. When m_tready is low the queue fills and s_tready falls; no record is
// lost.
// ----------------------------------------------------------------------------
module bgp_update_byte_parser_top #(
  parameter int unsigned MAX_BODY_BYTES = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // data_byte[7:0], body_length[19:8], zero
  input  logic         s_tuser,   // start_of_message
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // attr_type, attr_flags, value_a, value_b,
                                  // value_c, prefix_length, segment_type, status
  output logic [3:0]   m_tuser,   // record_kind
  output logic         m_tlast,   // last
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data   // asn_four_byte
);
  import bup_pkg::*;

  logic      fire;
  logic      asn_four_byte;
  logic      seen;
  seen_req_t seen_req;
  logic      main_v;
  logic      end_v;
  rec_t      main_rec;
  rec_t      end_rec;
  logic      room;
  rec_t      out_rec;

  assign cfg_ready = 1'b1;
  assign s_tready  = room;
  assign fire      = s_tvalid && s_tready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      asn_four_byte <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      asn_four_byte <= cfg_data;
    end
  end

  bup_parser #(
    .MAX_BODY_BYTES (MAX_BODY_BYTES)
  ) u_parser (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .data_byte        (s_tdata[7:0]),
    .start_of_message (s_tuser),
    .body_length      (s_tdata[19:8]),
    .asn4             (asn_four_byte),
    .seen             (seen),
    .seen_req         (seen_req),
    .main_v           (main_v),
    .main_rec         (main_rec),
    .end_v            (end_v),
    .end_rec          (end_rec)
  );

  bup_seen_map u_seen (
    .clk  (clk),
    .rst  (rst),
    .req  (seen_req),
    .seen (seen)
  );

  bup_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (fire && (main_v || end_v)),
    .data0     (main_v ? main_rec : end_rec),
    .push1     (fire && main_v && end_v),
    .data1     (end_rec),
    .room      (room),
    .out_valid (m_tvalid),
    .out_rec   (out_rec),
    .out_ready (m_tready)
  );

  // Output packing.
  assign m_tuser = out_rec.kind;
  assign m_tlast = out_rec.last;
  assign m_tdata = {out_rec.status, out_rec.seg, out_rec.plen, out_rec.vc,
                    out_rec.vb, out_rec.va, out_rec.aflags, out_rec.atype};

endmodule

// ===== verif/bgp_update_byte_parser_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BGP UPDATE byte parser testbench
// Feeds UPDATE bodies byte by byte: directed cases, then well-formed messages
// with random content mixed with broken ones and noise. A built-in record
// predictor works out the records of each accepted byte, and every record
// transaction on the output is compared with the oldest predicted record.
// Both sides idle at random, and one long receiver hold-off stalls the input.
// ----------------------------------------------------------------------------
module bgp_update_byte_parser_top_tb;
  import bup_pkg::*;

  localparam int unsigned BODY_LIMIT  = 4096;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned LC_BYTES    = 12;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [23:0]  s_tdata = '0;   // data_byte, body_length, zero
  logic         s_tuser = 1'b0; // start_of_message
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;        // attr_type, attr_flags, value_a, value_b,
                                // value_c, prefix_length, segment_type, status
  logic [3:0]   m_tuser;        // record_kind
  logic         m_tlast;        // last
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_data = 1'b0;

  bgp_update_byte_parser_top #(.MAX_BODY_BYTES(BODY_LIMIT)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Shared bench state.
  rec_t        expected_records[$];
  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          burst_mode = 1'b0;

  // Predictor state.
  phase_t      ph;
  bit          four_byte_asn;
  int unsigned msg_left, sec_left, attr_left, shift_reg, taken;
  int unsigned tf, seg_kind, asn_left, held0, held1, cur_plen;
  bit          seen[256];
  int unsigned n_out;

  // --------------------------------------------------------------------------
  // Record predictor
  // --------------------------------------------------------------------------
  function automatic void emit(int unsigned k, bit with_attr, int unsigned a,
                               int unsigned b, int unsigned c, int unsigned pl,
                               int unsigned sg, int unsigned st, bit lst);
    rec_t r;
    if (n_out >= 2) return;
    r.kind   = k[3:0];
    r.atype  = with_attr ? tf[15:8] : 8'd0;
    r.aflags = with_attr ? tf[7:0] : 8'd0;
    r.va     = a;
    r.vb     = b;
    r.vc     = c;
    r.plen   = pl[5:0];
    r.seg    = sg[7:0];
    r.status = st[1:0];
    r.last   = lst;
    expected_records.push_back(r);
    n_out++;
  endfunction

  function automatic void close_message(int unsigned st);
    emit(K_END, 1'b0, 0, 0, 0, 0, 0, st, 1'b1);
    ph = P_IDLE;
  endfunction

  function automatic int unsigned cur_type();
    return (tf >> 8) & 8'hFF;
  endfunction

  function automatic int unsigned asn_width();
    int unsigned t;
    t = cur_type();
    if (t == AT_AS4_PATH || t == AT_AS4_AGGR) return 4;
    return four_byte_asn ? 4 : 2;
  endfunction

  function automatic int unsigned group_bytes(int unsigned t);
    case (t)
      AT_ORIGIN: return 1;
      AT_NEXT_HOP, AT_MED, AT_LOCAL_PREF, AT_COMMUNITY, AT_ORIGINATOR,
      AT_CLUSTER: return 4;
      AT_AGGREGATOR: return asn_width() + 4;
      AT_AS4_AGGR: return 8;
      AT_PATH_LIMIT: return 3;
      AT_LARGE_COMM: return LC_BYTES;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned record_kind_for(int unsigned t);
    case (t)
      AT_ORIGIN: return K_ORIGIN;
      AT_NEXT_HOP: return K_NEXT_HOP;
      AT_MED: return K_MED;
      AT_LOCAL_PREF: return K_LOCAL_PREF;
      AT_AGGREGATOR, AT_AS4_AGGR: return K_AGGREGATOR;
      AT_COMMUNITY: return K_COMMUNITY;
      AT_ORIGINATOR: return K_ORIGINATOR;
      AT_CLUSTER: return K_CLUSTER;
      AT_PATH_LIMIT: return K_PATH_LIMIT;
      default: return K_LARGE_COMM;
    endcase
  endfunction

  function automatic bit is_list(int unsigned t);
    return t == AT_COMMUNITY || t == AT_CLUSTER || t == AT_LARGE_COMM;
  endfunction

  function automatic void start_field(phase_t p);
    shift_reg = 0;
    taken = 0;
    ph = p;
  endfunction

  function automatic void next_attribute();
    start_field(sec_left != 0 ? P_AFLAGS : P_NPLEN);
  endfunction

  function automatic void skip_rest();
    if (attr_left != 0) ph = P_ASKIP;
    else next_attribute();
  endfunction

  function automatic void clear_state();
    ph = P_IDLE;
    msg_left = 0; sec_left = 0; attr_left = 0; shift_reg = 0; taken = 0;
    tf = 0; seg_kind = 0; asn_left = 0; held0 = 0; held1 = 0; cur_plen = 0;
    foreach (seen[i]) seen[i] = 1'b0;
  endfunction

  // Returns 0 on a fault, 1 when the prefix is complete, 2 when bytes follow.
  function automatic int prefix_header(int unsigned b, int unsigned avail, int unsigned k);
    int unsigned nb;
    if (b > MAX_PREFIX_BITS) begin
      close_message(ST_PREFIX);
      return 0;
    end
    nb = (b + 7) / 8;
    if (nb > avail) begin
      close_message(ST_LENGTH);
      return 0;
    end
    cur_plen = b;
    shift_reg = 0;
    taken = 0;
    if (nb == 0) begin
      emit(k, 1'b0, 0, 0, 0, b, 0, ST_OK, 1'b0);
      return 1;
    end
    return 2;
  endfunction

  function automatic bit prefix_byte(int unsigned b, int unsigned k);
    int unsigned nb;
    nb = (cur_plen + 7) / 8;
    shift_reg |= b << ((24 - 8 * (taken & 3)) & 31);
    taken++;
    if (taken < nb) return 1'b0;
    emit(k, 1'b0, shift_reg, 0, 0, cur_plen, 0, ST_OK, 1'b0);
    return 1'b1;
  endfunction

  function automatic void header_done(int unsigned len);
    int unsigned t, g;
    t = cur_type();
    if (len > sec_left) begin
      close_message(ST_LENGTH);
      return;
    end
    attr_left = len;
    shift_reg = 0;
    taken = 0;
    if (seen[t]) begin
      emit(K_SKIPPED, 1'b1, 0, 0, 0, 0, 0, ST_DUPLICATE, 1'b0);
      skip_rest();
      return;
    end
    seen[t] = 1'b1;
    if (t == AT_AS_PATH || t == AT_AS4_PATH) begin
      if (len == 0) next_attribute();
      else ph = P_ASEGT;
      return;
    end
    if (t == AT_ATOMIC) begin
      emit(K_ATOMIC, 1'b1, 0, 0, 0, 0, 0, ST_OK, 1'b0);
      skip_rest();
      return;
    end
    g = group_bytes(t);
    if (g == 0) begin
      emit(K_SKIPPED, 1'b1, 0, 0, 0, 0, 0, ST_OK, 1'b0);
      skip_rest();
      return;
    end
    if (t == AT_LARGE_COMM && (len % LC_BYTES) != 0) begin
      close_message(ST_LENGTH);
      return;
    end
    if (len < g) begin
      if (!is_list(t)) emit(K_SKIPPED, 1'b1, 0, 0, 0, 0, 0, ST_OK, 1'b0);
      skip_rest();
      return;
    end
    ph = P_AVAL;
  endfunction

  function automatic void value_byte(int unsigned b);
    int unsigned t, g, k;
    t = cur_type();
    g = group_bytes(t);
    shift_reg = (shift_reg << 8) | b;
    taken++;
    k = taken;
    if (((t == AT_AGGREGATOR || t == AT_AS4_AGGR) && k == asn_width()) ||
        (t == AT_PATH_LIMIT && k == 1) || (t == AT_LARGE_COMM && k == 4)) begin
      held0 = shift_reg;
      shift_reg = 0;
    end else if (t == AT_LARGE_COMM && k == 8) begin
      held1 = shift_reg;
      shift_reg = 0;
    end
    if (k < g) return;
    if (t == AT_AGGREGATOR || t == AT_AS4_AGGR || t == AT_PATH_LIMIT)
      emit(record_kind_for(t), 1'b1, held0, shift_reg, 0, 0, 0, ST_OK, 1'b0);
    else if (t == AT_LARGE_COMM)
      emit(K_LARGE_COMM, 1'b1, held0, held1, shift_reg, 0, 0, ST_OK, 1'b0);
    else
      emit(record_kind_for(t), 1'b1, shift_reg, 0, 0, 0, 0, ST_OK, 1'b0);
    shift_reg = 0;
    taken = 0;
    if (!(is_list(t) && attr_left >= g)) skip_rest();
  endfunction

  // Works out the records caused by one accepted byte.
  function automatic void predict_byte(int unsigned b, bit start, int unsigned blen);
    int unsigned len, need;
    int r;
    n_out = 0;
    if (start) begin
      clear_state();
      msg_left = blen > BODY_LIMIT ? BODY_LIMIT : blen;
      ph = P_WLEN;
    end
    if (ph == P_IDLE) return;
    if (msg_left == 0) begin
      close_message(ST_LENGTH);
      return;
    end
    msg_left--;
    case (ph)
      P_WLEN, P_ALEN: begin
        shift_reg = (shift_reg << 8) | b;
        taken++;
        if (taken >= 2) begin
          len = shift_reg & 16'hFFFF;
          if (len > msg_left) begin
            close_message(ST_LENGTH);
          end else begin
            sec_left = len;
            if (ph == P_WLEN) start_field(len != 0 ? P_WPLEN : P_ALEN);
            else start_field(len != 0 ? P_AFLAGS : P_NPLEN);
          end
        end
      end
      P_WPLEN, P_WPFX: begin
        sec_left--;
        if (ph == P_WPLEN) begin
          r = prefix_header(b, sec_left, K_WITHDRAWN);
          if (r == 2) ph = P_WPFX;
        end else if (prefix_byte(b, K_WITHDRAWN)) begin
          ph = P_WPLEN;
        end
        if (ph == P_WPLEN && sec_left == 0) start_field(P_ALEN);
      end
      P_AFLAGS: begin
        sec_left--;
        tf = b;
        if (sec_left == 0) close_message(ST_LENGTH);
        else ph = P_ATYPE;
      end
      P_ATYPE: begin
        sec_left--;
        tf = (b << 8) | (tf & 8'hFF);
        if (sec_left == 0) close_message(ST_LENGTH);
        else start_field(P_ALENB);
      end
      P_ALENB: begin
        sec_left--;
        shift_reg = (shift_reg << 8) | b;
        taken++;
        need = (tf & FLAG_EXT_LEN) != 0 ? 2 : 1;
        if (taken < need) begin
          if (sec_left == 0) close_message(ST_LENGTH);
        end else begin
          header_done(shift_reg & 16'hFFFF);
        end
      end
      P_AVAL: begin
        sec_left--;
        attr_left--;
        value_byte(b);
      end
      P_ASKIP: begin
        sec_left--;
        attr_left--;
        if (attr_left == 0) next_attribute();
      end
      P_ASEGT: begin
        sec_left--;
        attr_left--;
        seg_kind = b;
        if (attr_left == 0) close_message(ST_LENGTH);
        else ph = P_ASEGN;
      end
      P_ASEGN: begin
        sec_left--;
        attr_left--;
        if (b * asn_width() > attr_left) begin
          close_message(ST_LENGTH);
        end else begin
          asn_left = b;
          if (b != 0) start_field(P_ASN);
          else if (attr_left == 0) next_attribute();
          else ph = P_ASEGT;
        end
      end
      P_ASN: begin
        sec_left--;
        attr_left--;
        shift_reg = (shift_reg << 8) | b;
        taken++;
        if (taken >= asn_width()) begin
          emit(K_ASN, 1'b1, shift_reg, 0, 0, 0, seg_kind, ST_OK, 1'b0);
          shift_reg = 0;
          taken = 0;
          if (asn_left > 0) asn_left--;
          if (!(asn_left > 0 && attr_left > 0)) begin
            if (attr_left == 0) next_attribute();
            else ph = P_ASEGT;
          end
        end
      end
      P_NPLEN: begin
        r = prefix_header(b, msg_left, K_ANNOUNCED);
        if (r == 2) ph = P_NPFX;
      end
      P_NPFX: begin
        if (prefix_byte(b, K_ANNOUNCED)) ph = P_NPLEN;
      end
      default: ph = P_IDLE;
    endcase
    if (ph != P_IDLE && msg_left == 0)
      close_message(ph == P_NPLEN ? ST_OK : ST_LENGTH);
  endfunction

  // --------------------------------------------------------------------------
  // Message builder
  // --------------------------------------------------------------------------
  function automatic void add_prefix(ref logic [7:0] q[$]);
    int unsigned pl;
    pl = $urandom_range(0, 32);
    q.push_back(pl[7:0]);
    for (int i = 0; i < (pl + 7) / 8; i++) q.push_back($urandom);
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 15))
      0: return AT_ORIGIN;
      1: return AT_AS_PATH;
      2: return AT_NEXT_HOP;
      3: return AT_MED;
      4: return AT_LOCAL_PREF;
      5: return AT_ATOMIC;
      6: return AT_AGGREGATOR;
      7: return AT_COMMUNITY;
      8: return AT_ORIGINATOR;
      9: return AT_CLUSTER;
      10: return AT_AS4_PATH;
      11: return AT_AS4_AGGR;
      12: return AT_PATH_LIMIT;
      13: return AT_LARGE_COMM;
      default: return $urandom;
    endcase
  endfunction

  // Value bytes of one attribute; with tweak set the length is sometimes bent.
  function automatic void attr_value(logic [7:0] t, bit tweak, ref logic [7:0] v[$]);
    int unsigned w, n;
    w = (t == AT_AS4_PATH || t == AT_AS4_AGGR || four_byte_asn) ? 4 : 2;
    case (t)
      AT_ORIGIN: n = 1;
      AT_NEXT_HOP, AT_MED, AT_LOCAL_PREF, AT_ORIGINATOR: n = 4;
      AT_ATOMIC: n = 0;
      AT_AGGREGATOR, AT_AS4_AGGR: n = w + 4;
      AT_PATH_LIMIT: n = 3;
      AT_COMMUNITY, AT_CLUSTER: n = 4 * $urandom_range(0, 3);
      AT_LARGE_COMM: n = LC_BYTES * $urandom_range(0, 2);
      default: n = $urandom_range(0, 5);
    endcase
    if (t == AT_AS_PATH || t == AT_AS4_PATH) begin
      n = 0;
      repeat ($urandom_range(0, 2)) begin
        int unsigned c;
        c = $urandom_range(0, 3);
        v.push_back($urandom);
        v.push_back(c[7:0]);
        repeat (c * w) v.push_back($urandom);
      end
    end else begin
      repeat (n) v.push_back($urandom);
    end
    // Trailing bytes, or a value cut short.
    if (tweak && $urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 1) && v.size() > 0) void'(v.pop_back());
      else repeat ($urandom_range(1, 3)) v.push_back($urandom);
    end
  endfunction

  function automatic void build_body(int n_wd, logic [7:0] types[$], int n_ann, bit tweak,
                                     ref logic [7:0] m[$]);
    logic [7:0] wd[$], at[$], an[$], v[$];
    logic [7:0] fl;
    repeat (n_wd) add_prefix(wd);
    foreach (types[i]) begin
      v.delete();
      attr_value(types[i], tweak, v);
      fl = $urandom;
      at.push_back(fl);
      at.push_back(types[i]);
      if (fl & FLAG_EXT_LEN) at.push_back(v.size() >> 8);
      at.push_back(v.size() & 8'hFF);
      at = {at, v};
    end
    repeat (n_ann) add_prefix(an);
    m.delete();
    m.push_back(wd.size() >> 8);
    m.push_back(wd.size() & 8'hFF);
    m = {m, wd};
    m.push_back(at.size() >> 8);
    m.push_back(at.size() & 8'hFF);
    m = {m, at, an};
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 70) return;
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (r < 95 ? $urandom_range(0, 2) : $urandom_range(10, 40)) @(negedge clk);
  endtask

  // One byte transaction; valid stays high unless a gap follows.
  task automatic send_byte(logic [7:0] b, bit start, logic [11:0] blen);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, blen, b};
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    predict_byte(b, start, blen);
    bytes_sent++;
    idle_gap();
  endtask

  task automatic send_message(logic [7:0] m[$], int unsigned blen);
    foreach (m[i]) send_byte(m[i], i == 0, i == 0 ? blen[11:0] : 12'($urandom));
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_asn_width(bit v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    four_byte_asn = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_idle_and_restart();
    logic [7:0] m[$];
    repeat (3) send_byte($urandom, 1'b0, 12'hFFF);
    // A start with the largest length, abandoned by a fresh start.
    send_byte(8'h00, 1'b1, 12'hFFF);
    send_byte(8'hFF, 1'b0, 12'h000);
    build_body(1, '{AT_ORIGIN}, 1, 1'b0, m);
    send_message(m, m.size());
    drain();
  endtask

  task automatic test_short_bodies();
    logic [7:0] m[$];
    send_byte(8'hAA, 1'b1, 12'd0);
    build_body(1, '{AT_MED}, 0, 1'b0, m);
    send_message(m, m.size() - 3);
    // Withdrawn section longer than the body.
    send_message('{8'h00, 8'h40, 8'h08}, 3);
    drain();
  endtask

  task automatic test_each_attribute();
    logic [7:0] m[$];
    logic [7:0] all[$];
    all = '{AT_ORIGIN, AT_AS_PATH, AT_NEXT_HOP, AT_MED, AT_LOCAL_PREF, AT_ATOMIC,
            AT_AGGREGATOR, AT_COMMUNITY, AT_ORIGINATOR, AT_CLUSTER, AT_AS4_PATH,
            AT_AS4_AGGR, AT_PATH_LIMIT, AT_LARGE_COMM, 8'd99};
    build_body(1, all, 2, 1'b0, m);
    send_message(m, m.size());
    // Duplicate attribute.
    build_body(0, '{AT_LOCAL_PREF, AT_LOCAL_PREF}, 1, 1'b0, m);
    send_message(m, m.size());
    drain();
  endtask

  task automatic test_prefix_faults();
    // Withdrawn prefix of 33 bits, then an announced one of 255 bits.
    send_message('{8'h00, 8'h02, 8'd33, 8'h00, 8'h00, 8'h00}, 6);
    send_message('{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h01}, 6);
    // Announced prefix whose bytes run past the body.
    send_message('{8'h00, 8'h00, 8'h00, 8'h00, 8'd32, 8'h0A}, 6);
    drain();
  endtask

  task automatic test_backpressure();
    logic [7:0] m[$];
    m = '{8'h00, 8'h00, 8'h00, 8'h00};
    repeat (40) m.push_back(8'h00);
    hold_left = 300;
    burst_mode = 1'b1;
    send_message(m, m.size());
    burst_mode = 1'b0;
    drain();
  endtask

  task automatic test_random_traffic();
    logic [7:0] m[$];
    logic [7:0] types[$];
    int unsigned msgs, r, blen;
    msgs = 0;
    while (bytes_sent < 1900) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        types.delete();
        repeat ($urandom_range(0, 5)) types.push_back(pick_type());
        build_body($urandom_range(0, 3), types, $urandom_range(0, 3), r < 30, m);
        blen = m.size();
        if (r < 8) m[$urandom_range(0, m.size() - 1)] = $urandom;
        else if (r < 12) blen = $urandom_range(1, m.size());
        send_message(m, blen);
      end else if (r < 90) begin
        // Noise: a start with any length and a few random bytes.
        m.delete();
        repeat ($urandom_range(1, 12)) m.push_back($urandom);
        send_message(m, $urandom_range(0, 4095));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte($urandom, 1'b0, 12'($urandom));
      end
      msgs++;
      if (msgs % 40 == 0) write_asn_width($urandom_range(0, 1));
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Receiver with random stalls and the counted hold-off
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    int unsigned pick;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 15) stall = $urandom_range(1, 3);
        else if (pick < 18) stall = $urandom_range(10, 40);
        else stall = 0;
      end
    end
  end

  // Record checker.
  always @(posedge clk) begin
    rec_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{kind: m_tuser, atype: m_tdata[7:0], aflags: m_tdata[15:8],
              va: m_tdata[47:16], vb: m_tdata[79:48], vc: m_tdata[111:80],
              plen: m_tdata[117:112], seg: m_tdata[125:118],
              status: m_tdata[127:126], last: m_tlast};
      if (expected_records.size() == 0) begin
        $display("%0t: record with none expected, actual %p", $time, got);
        fail_count++;
      end else begin
        want = expected_records.pop_front();
        if (got !== want) begin
          $display("%0t: record mismatch, expected %p, actual %p", $time, want, got);
          fail_count++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_state();
    four_byte_asn = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_asn_width(1'b0);
    test_idle_and_restart();
    test_short_bodies();
    test_each_attribute();
    write_asn_width(1'b1);
    test_each_attribute();
    test_prefix_faults();
    test_backpressure();
    test_random_traffic();
    if (fail_count == 0 && expected_records.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bup_pkg.sv
rtl/bup_seen_map.sv
rtl/bup_parser.sv
rtl/bup_out_fifo.sv
rtl/bgp_update_byte_parser_top.sv
verif/bgp_update_byte_parser_top_tb.sv
